// ===== sv/sst_pkg.sv =====
// shared constants, codes and types for the sorted string table search block
// no dependencies
package sst_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_LEN     = 32;

    // index widths derived from the storage geometry
    localparam int ENT_W  = $clog2(TABLE_DEPTH);
    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = ENT_W + 1;
    localparam int TBL_AW = ENT_W + POS_W;

    // port field widths
    localparam int FUNC_W     = 2;
    localparam int ENTRY_IX_W = 8;
    localparam int BYTE_POS_W = 5;
    localparam int BYTE_W     = 8;
    localparam int RES_W      = 9;

    // function codes
    localparam logic [FUNC_W-1:0] FN_WR_ENTRY = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WR_KEY   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH   = 2'd2;

    // write request towards the string store
    typedef struct packed {
        logic              tbl_we;
        logic              key_we;
        logic [ENT_W-1:0]  ent;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
        logic              nul;
    } t_wr_req;

    // read addresses into the string store
    typedef struct packed {
        logic [ENT_W-1:0] ent;
        logic [POS_W-1:0] pos;
    } t_rd_req;

    // registered read data from the string store
    typedef struct packed {
        logic [BYTE_W-1:0] tbl;
        logic [BYTE_W-1:0] key;
        logic              nul;
    } t_rd_data;

endpackage

// ===== sv/sst_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sst_store.sv =====
// string store: table bytes, entry null flags and key bytes in three rams
// depends on sst_pkg and sst_ram
module sst_store (
    input  logic              i_clk,
    input  sst_pkg::t_wr_req  i_wr,
    input  sst_pkg::t_rd_req  i_rd,
    output sst_pkg::t_rd_data o_rd
);
    import sst_pkg::*;

    logic [BYTE_W-1:0] tbl_q;
    logic [BYTE_W-1:0] key_q;
    logic [0:0]        nul_q;

    // entry-major layout: entry in the upper address bits
    sst_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH * MAX_LEN)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.tbl_we),
        .i_waddr ({i_wr.ent, i_wr.pos}),
        .i_wdata (i_wr.data),
        .i_raddr ({i_rd.ent, i_rd.pos}),
        .o_rdata (tbl_q)
    );

    sst_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_nul_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.tbl_we),
        .i_waddr (i_wr.ent),
        .i_wdata (i_wr.nul),
        .i_raddr (i_rd.ent),
        .o_rdata (nul_q)
    );

    sst_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.key_we),
        .i_waddr (i_wr.pos),
        .i_wdata (i_wr.data),
        .i_raddr (i_rd.pos),
        .o_rdata (key_q)
    );

    assign o_rd.tbl = tbl_q;
    assign o_rd.key = key_q;
    assign o_rd.nul = nul_q[0];

endmodule

// ===== sv/sorted_string_table_search.sv =====
// top level of the sorted string table search: command decode, search sequencer
// depends on sst_pkg and sst_store
//
// a command is taken when start is high and busy is low. table and key byte
// writes finish in that cycle and leave busy low. a search raises busy, runs a
// binary search over the first entry_count entries (clamped to the table depth)
// and presents one result for exactly one cycle on o_result_strobe, with
// o_result_index and o_found; the receiver cannot stall it, so it must take the
// result in that cycle. an empty table or a null key gives its result in the
// cycle after the command without raising busy. otherwise each probe forms the
// midpoint, then reads table and key bytes through the registered rams and
// compares one byte while the next is read, and a search makes at most
// log2(count)+1 probes (9 for a full table of 256).
// the byte-serial compare is set by the single read port of the table byte ram.
// entry_count is written through the cfg channel, which is ready while idle.
module sorted_string_table_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sst_pkg::FUNC_W-1:0]        i_func,
    input  logic [sst_pkg::ENTRY_IX_W-1:0]    i_entry_index,
    input  logic [sst_pkg::BYTE_POS_W-1:0]    i_byte_pos,
    input  logic [sst_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                              i_is_null,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sst_pkg::CNT_W-1:0]         i_cfg_data,
    output logic                              o_result_strobe,
    output logic [sst_pkg::RES_W-1:0]         o_result_index,
    output logic                              o_found
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MID  = 3'b010,
        S_CMP  = 3'b100
    } t_state;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(TABLE_DEPTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LEN - 1);

    // control state
    t_state           r_state, n_state;
    logic             r_strobe, n_strobe;
    logic             r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0] r_entry_count;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;

    // payload
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ENT_W-1:0] r_mid, n_mid;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_cmp_pos, n_cmp_pos;
    logic [RES_W-1:0] r_res, n_res;
    logic             r_found, n_found;

    logic             accept;
    logic             entry_ok;
    logic [CNT_W-1:0] cnt_clamp;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] lo_nx;
    logic [CNT_W-1:0] hi_nx;
    logic             c_less;
    logic             c_greater;
    logic             c_equal;

    t_wr_req  wr;
    t_rd_req  rd;
    t_rd_data rd_q;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // entries beyond the table are dropped
    assign entry_ok = (32'(i_entry_index) < TABLE_DEPTH);

    // command decode into store writes
    always_comb begin
        wr.tbl_we = 1'b0;
        wr.key_we = 1'b0;
        wr.ent    = i_entry_index[ENT_W-1:0];
        wr.pos    = i_byte_pos[POS_W-1:0];
        wr.data   = i_byte_value;
        wr.nul    = i_is_null;
        unique case (i_func)
            FN_WR_ENTRY: wr.tbl_we = accept && entry_ok;
            FN_WR_KEY:   wr.key_we = accept;
            default:     ;
        endcase
    end

    // reads follow the probe in flight
    assign rd.ent = r_mid;
    assign rd.pos = r_pos;

    sst_store u_store (
        .i_clk (i_clk),
        .i_wr  (wr),
        .i_rd  (rd),
        .o_rd  (rd_q)
    );

    assign cnt_clamp = (r_entry_count > CNT_MAX) ? CNT_MAX : r_entry_count;

    // midpoint of the live interval, always below hi so it fits an entry index
    assign mid_calc = r_lo + ((r_hi - r_lo) >> 1);

    // byte compare on the data coming back from the rams
    // null entry sorts below any key; a string filling every byte ends there
    always_comb begin
        c_less    = 1'b0;
        c_greater = 1'b0;
        c_equal   = 1'b0;
        if (rd_q.nul) begin
            c_less = 1'b1;
        end else if (rd_q.tbl != rd_q.key) begin
            c_less    = (rd_q.tbl < rd_q.key);
            c_greater = !(rd_q.tbl < rd_q.key);
        end else if ((rd_q.tbl == '0) || (r_cmp_pos == LAST_POS)) begin
            c_equal = 1'b1;
        end
    end

    assign lo_nx = c_less    ? ({1'b0, r_mid} + CNT_W'(1)) : r_lo;
    assign hi_nx = c_greater ? {1'b0, r_mid}               : r_hi;

    // search sequencer
    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_cmp_vld = 1'b0;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_cnt     = r_cnt;
        n_mid     = r_mid;
        n_pos     = r_pos;
        n_cmp_pos = r_cmp_pos;
        n_res     = r_res;
        n_found   = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_func == FN_SEARCH)) begin
                    n_cnt = cnt_clamp;
                    n_lo  = '0;
                    n_hi  = cnt_clamp;
                    if ((cnt_clamp == '0) || i_is_null) begin
                        // nothing to probe, answer straight away
                        n_strobe = 1'b1;
                        n_res    = RES_W'(cnt_clamp);
                        n_found  = 1'b0;
                    end else begin
                        n_state = S_MID;
                    end
                end
            end
            S_MID: begin
                n_mid   = mid_calc[ENT_W-1:0];
                n_pos   = '0;
                n_state = S_CMP;
            end
            S_CMP: begin
                // issue the next byte read while the previous one is compared
                n_pos     = r_pos + POS_W'(1);
                n_cmp_pos = r_pos;
                n_cmp_vld = 1'b1;
                if (r_cmp_vld && (c_less || c_greater || c_equal)) begin
                    n_cmp_vld = 1'b0;
                    if (c_equal) begin
                        n_strobe = 1'b1;
                        n_res    = RES_W'(r_mid);
                        n_found  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_lo = lo_nx;
                        n_hi = hi_nx;
                        if (lo_nx < hi_nx) begin
                            n_state = S_MID;
                        end else begin
                            n_strobe = 1'b1;
                            n_res    = RES_W'(r_cnt);
                            n_found  = 1'b0;
                            n_state  = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strobe      <= 1'b0;
            r_cmp_vld     <= 1'b0;
            r_entry_count <= '0;
            r_lo          <= '0;
            r_hi          <= '0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_cmp_vld <= n_cmp_vld;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            if (i_cfg_valid && o_cfg_ready) begin
                r_entry_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_mid     <= n_mid;
        r_pos     <= n_pos;
        r_cmp_pos <= n_cmp_pos;
        r_res     <= n_res;
        r_found   <= n_found;
    end

    assign o_result_strobe = r_strobe;
    assign o_result_index  = r_res;
    assign o_found         = r_found;

endmodule

// ===== sv/sst_chk.sv =====
// port-level checks for the sorted string table search, bound to the top level
// depends on sst_pkg
module sst_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [sst_pkg::FUNC_W-1:0]     i_func,
    input logic                           o_result_strobe,
    input logic [sst_pkg::RES_W-1:0]      o_result_index,
    input logic                           o_found
);
    import sst_pkg::*;

    // a hit always names a real table entry
    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_found) |-> (32'(o_result_index) < TABLE_DEPTH))
        else $error("hit index beyond table");

    // a result only follows a search command or a running search
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && $past(i_rst_n)) |->
            ($past(busy) || $past(start && !busy && (i_func == FN_SEARCH))))
        else $error("result without a search");

    // end of a running search always shows its result
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_result_strobe)
        else $error("search ended without a result");

    // byte writes finish at once and give no result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_func == FN_WR_ENTRY) || (i_func == FN_WR_KEY)))
            |=> (!busy && !o_result_strobe))
        else $error("byte write disturbed the sequencer");

endmodule

bind sorted_string_table_search sst_chk u_sst_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_func          (i_func),
    .o_result_strobe (o_result_strobe),
    .o_result_index  (o_result_index),
    .o_found         (o_found)
);
